[rtl/core/wildcard_byte_pattern_scanner_top_macros.svh]
// assertion macros for the wildcard byte pattern scanner
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_TOP_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define WBPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define WBPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/wbps_pkg.sv]
// shared constants and types of the wildcard byte pattern scanner
package wbps_pkg;

  // sizing
  localparam int MAX_PATTERN_LEN = 16;
  localparam int OFFSET_BITS     = 32;
  localparam int SLOT_COUNT      = 16;
  localparam int USABLE_LEN      = (MAX_PATTERN_LEN < SLOT_COUNT) ? MAX_PATTERN_LEN : SLOT_COUNT;
  localparam int CELL_COUNT      = USABLE_LEN;
  localparam int SLOT_IDX_W      = $clog2(SLOT_COUNT);
  localparam int LEN_W           = 5;
  localparam int OUT_OFFSET_W    = 32;
  localparam int CARE_W          = 16;
  localparam int DATA_W          = 64;
  localparam int ADDR_W          = 5;
  localparam int REG_ADDR_LO     = 3;

  // register indexes
  typedef enum logic [1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_PATTERN_LOW    = 2'd1,
    REG_PATTERN_HIGH   = 2'd2,
    REG_CARE_MASK      = 2'd3
  } wbps_reg_e_t;

  // reset values of the registers
  localparam logic [LEN_W-1:0]  PATTERN_LENGTH_RST = LEN_W'(1);
  localparam logic [CARE_W-1:0] CARE_MASK_RST      = {CARE_W{1'b1}};

  // saturation limit of the byte count
  localparam logic [OFFSET_BITS-1:0] COUNT_MAX = {OFFSET_BITS{1'b1}};

  // per-cell compare control
  typedef struct packed {
    logic       in_use;
    logic       care;
    logic [7:0] exp_byte;
  } wbps_cell_ctl_t;

endpackage

[rtl/core/wbps_if.sv]
// byte input and result channel interfaces

interface wbps_in_if import wbps_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_out_if import wbps_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    found;
  logic [OUT_OFFSET_W-1:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

[rtl/core/wildcard_byte_pattern_scanner_top.sv]
// top level of the wildcard byte pattern scanner: cell chain, count and result register
//
//   channel   direction  handshake            payload
//   in_chan   in         valid/ready          data_byte, last_byte
//   out_chan  out        valid/ready          found, match_offset
//   cfg_*     in         apb write/read       pattern_length, pattern bytes, care_mask
//
// one byte per cycle unless stalled; all cells compare in the cycle a byte arrives
// a result appears in the output register the cycle after its byte is taken
// input is stalled only while a result waits in the output register and out ready is low
// synchronous active-low reset clears count, match flag, output valid; resets registers
// the window is not cleared between regions; the byte count masks stale bytes
`include "wildcard_byte_pattern_scanner_top_macros.svh"

module wildcard_byte_pattern_scanner_top import wbps_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  wbps_in_if.sink             in_chan,
  wbps_out_if.source          out_chan,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [ADDR_W-1:0]   cfg_paddr,
  input  logic [DATA_W-1:0]   cfg_pwdata,
  output logic [DATA_W-1:0]   cfg_prdata,
  output logic                cfg_pready
);

  logic [LEN_W-1:0]                len_eff;
  wbps_cell_ctl_t [CELL_COUNT-1:0] cell_ctl;
  logic [7:0]                      win [CELL_COUNT];
  logic [7:0]                      cell_in [CELL_COUNT];
  logic [CELL_COUNT-1:0]           cell_match;

  logic [OFFSET_BITS-1:0]  bytes_seen_r, bytes_seen_nxt;
  logic                    matched_r, matched_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    found_r, found_nxt;
  logic [OUT_OFFSET_W-1:0] offset_r, offset_nxt;

  logic                    accept;
  logic                    active;
  logic                    hit;
  logic                    emit;
  logic [OFFSET_BITS-1:0]  count_after;

  assign cfg_pready = 1'b1;

  wbps_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .len_eff     (len_eff),
    .cell_ctl    (cell_ctl)
  );

  // handshake
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign active        = accept && !matched_r;

  // cell chain, newest byte enters cell zero
  for (genvar w = 0; w < CELL_COUNT; w++) begin : g_cell
    if (w == 0) begin : g_head
      assign cell_in[w] = in_chan.data_byte;
    end else begin : g_body
      assign cell_in[w] = win[w-1];
    end
    wbps_cell u_cell (
      .clk      (clk),
      .shift_en (active),
      .byte_in  (cell_in[w]),
      .ctl      (cell_ctl[w]),
      .byte_out (win[w]),
      .match    (cell_match[w])
    );
  end

  // saturating count and match decision
  assign count_after = (bytes_seen_r == COUNT_MAX) ? COUNT_MAX
                                                   : bytes_seen_r + OFFSET_BITS'(1);
  assign hit  = active && (count_after >= OFFSET_BITS'(len_eff)) && (&cell_match);
  assign emit = hit || (active && in_chan.last_byte);

  // region state
  always_comb begin
    bytes_seen_nxt = bytes_seen_r;
    matched_nxt    = matched_r;
    if (accept && in_chan.last_byte) begin
      bytes_seen_nxt = '0;
      matched_nxt    = 1'b0;
    end else if (active) begin
      bytes_seen_nxt = count_after;
      matched_nxt    = hit;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_chan.ready;
    found_nxt     = found_r;
    offset_nxt    = offset_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      found_nxt     = hit;
      offset_nxt    = hit ? OUT_OFFSET_W'(count_after - OFFSET_BITS'(len_eff)) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= '0;
      matched_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      bytes_seen_r <= bytes_seen_nxt;
      matched_r    <= matched_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r  <= found_nxt;
    offset_r <= offset_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.found        = found_r;
  assign out_chan.match_offset = offset_r;

  // checks
  `WBPS_ASSERT_NEXT(a_region_clears, accept && in_chan.last_byte, bytes_seen_r == '0 && !matched_r, "region state not cleared after last byte")
  `WBPS_ASSERT_NEXT(a_hit_reported, hit, out_valid_r && found_r, "match not presented on result channel")
  `WBPS_ASSERT_NOW(a_miss_offset_zero, out_valid_r && !found_r, offset_r == '0, "miss result carries non-zero offset")
  `WBPS_ASSERT_NOW(a_stall_blocks_input, out_valid_r && !out_chan.ready, !in_chan.ready, "input taken while result is stalled")

endmodule

[rtl/core/wbps_cell.sv]
// one window cell: holds a byte, compares the byte it takes in, passes its own on
module wbps_cell import wbps_pkg::*; (
  input  logic           clk,
  input  logic           shift_en,
  input  logic [7:0]     byte_in,
  input  wbps_cell_ctl_t ctl,
  output logic [7:0]     byte_out,
  output logic           match
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  // shift when a byte is taken before the region has matched
  assign byte_nxt = shift_en ? byte_in : byte_r;

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  // compare the incoming byte, which becomes this cell's content
  assign match    = !ctl.in_use || !ctl.care || (byte_in == ctl.exp_byte);
  assign byte_out = byte_r;

endmodule

[rtl/core/wbps_cfg.sv]
// register file and per-cell pattern alignment
module wbps_cfg import wbps_pkg::*; (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [ADDR_W-1:0]                cfg_paddr,
  input  logic [DATA_W-1:0]                cfg_pwdata,
  output logic [DATA_W-1:0]                cfg_prdata,
  output logic [LEN_W-1:0]                 len_eff,
  output wbps_cell_ctl_t [CELL_COUNT-1:0]  cell_ctl
);

  logic [LEN_W-1:0]  len_r,  len_nxt;
  logic [DATA_W-1:0] low_r,  low_nxt;
  logic [DATA_W-1:0] high_r, high_nxt;
  logic [CARE_W-1:0] care_r, care_nxt;
  logic              wr_en;
  logic [1:0]        reg_idx;
  logic [7:0]        pat [SLOT_COUNT];

  assign wr_en   = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx = cfg_paddr[ADDR_W-1:REG_ADDR_LO];

  // register writes
  always_comb begin
    len_nxt  = len_r;
    low_nxt  = low_r;
    high_nxt = high_r;
    care_nxt = care_r;
    if (wr_en) begin
      case (reg_idx)
        REG_PATTERN_LENGTH: len_nxt  = cfg_pwdata[LEN_W-1:0];
        REG_PATTERN_LOW:    low_nxt  = cfg_pwdata;
        REG_PATTERN_HIGH:   high_nxt = cfg_pwdata;
        REG_CARE_MASK:      care_nxt = cfg_pwdata[CARE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= PATTERN_LENGTH_RST;
      low_r  <= '0;
      high_r <= '0;
      care_r <= CARE_MASK_RST;
    end else begin
      len_r  <= len_nxt;
      low_r  <= low_nxt;
      high_r <= high_nxt;
      care_r <= care_nxt;
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_PATTERN_LENGTH: cfg_prdata = DATA_W'(len_r);
      REG_PATTERN_LOW:    cfg_prdata = low_r;
      REG_PATTERN_HIGH:   cfg_prdata = high_r;
      REG_CARE_MASK:      cfg_prdata = DATA_W'(care_r);
      default:            cfg_prdata = '0;
    endcase
  end

  // clamp length into one to the usable maximum
  always_comb begin
    if (len_r == '0)
      len_eff = LEN_W'(1);
    else if (len_r > LEN_W'(USABLE_LEN))
      len_eff = LEN_W'(USABLE_LEN);
    else
      len_eff = len_r;
  end

  // pattern bytes as slots
  for (genvar p = 0; p < SLOT_COUNT; p++) begin : g_pat
    if (p < 8) begin : g_low
      assign pat[p] = low_r[8*p +: 8];
    end else begin : g_high
      assign pat[p] = high_r[8*(p-8) +: 8];
    end
  end

  // cell w holds the byte that pattern position len-1-w must match
  for (genvar w = 0; w < CELL_COUNT; w++) begin : g_ctl
    logic [LEN_W-1:0] pos;
    assign pos                  = len_eff - LEN_W'(w) - LEN_W'(1);
    assign cell_ctl[w].in_use   = LEN_W'(w) < len_eff;
    assign cell_ctl[w].care     = care_r[pos[SLOT_IDX_W-1:0]];
    assign cell_ctl[w].exp_byte = pat[pos[SLOT_IDX_W-1:0]];
  end

endmodule
